// ===== sv/jac_pkg.sv =====
package jac_pkg;

	// Fixed item geometry.
	localparam int RAW_AXES   = 6;   // raw axis fields carried by one request
	localparam int SLOTS      = 8;   // axis slots addressable by a 3-bit source index
	localparam int NUM_CTRL   = 4;   // forward, lateral, vertical, yaw
	localparam int CNT_W      = 11;  // width of a raw axis or a control
	localparam int DZ_W       = 10;
	localparam int SRC_W      = 3;
	localparam int CFG_IDX_W  = 3;

	localparam int AXIS_FULL_SCALE = 1000;

	// Working width: holds a centered difference of two raw counts and the full scale.
	localparam int FS_W  = $clog2(AXIS_FULL_SCALE + 1) + 1;
	localparam int VAL_W = (FS_W > CNT_W + 1) ? FS_W : CNT_W + 1;

	typedef logic signed [CNT_W-1:0] cnt_t;
	typedef logic signed [VAL_W-1:0] val_t;

	localparam val_t FULL_POS = val_t'(AXIS_FULL_SCALE);
	localparam val_t FULL_NEG = val_t'(-AXIS_FULL_SCALE);

	typedef enum logic [1:0] {
		CMD_SAMPLE    = 2'd0,
		CMD_CALIBRATE = 2'd1,
		CMD_ENABLE    = 2'd2,
		CMD_DISABLE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_SAMPLED     = 3'd0,
		ST_CENTERED    = 3'd1,
		ST_ENABLED     = 3'd2,
		ST_STANDBY     = 3'd3,
		ST_NO_DEVICE   = 3'd4,
		ST_NOT_CAL     = 3'd5,
		ST_DEVICE_LOST = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADZONE   = 3'd0,
		REG_FWD_SRC    = 3'd1,
		REG_LAT_SRC    = 3'd2,
		REG_VERT_SRC   = 3'd3,
		REG_YAW_SRC    = 3'd4,
		REG_INVERT     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DZ_W-1:0]                 deadzone;
		logic [NUM_CTRL-1:0][SRC_W-1:0]  src;     // index 0 forward .. 3 yaw
		logic [NUM_CTRL-1:0]             invert;
	} cfg_t;

	localparam logic [DZ_W-1:0]  DEADZONE_RST = 10'd50;
	localparam logic [SRC_W-1:0] FWD_SRC_RST  = 3'd1;
	localparam logic [SRC_W-1:0] LAT_SRC_RST  = 3'd0;
	localparam logic [SRC_W-1:0] VERT_SRC_RST = 3'd2;
	localparam logic [SRC_W-1:0] YAW_SRC_RST  = 3'd5;

endpackage

// ===== sv/joystick_axis_conditioner.sv =====
// Joystick axis conditioner: center calibration, deadzone, saturation and control mapping.
// A request is registered on acceptance; its result is registered when the request
// advances into the result register, which it cannot do while an earlier result waits.
// Throughput: one request per cycle unless output stalls; state updates as results load.
// Reset: arst_n clears calibration, enable, centers, held controls and the handshake
// valids, and returns the configuration registers to their documented defaults.
module joystick_axis_conditioner
	import jac_pkg::*;
#(
	parameter int NUM_AXES = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// raw_x [10:0], raw_y [21:11], raw_z [32:22], raw_rx [43:33], raw_ry [54:44],
	// raw_rz [65:55], zero fill [71:66]
	input  logic [71:0]           s_axis_tdata,
	// command [1:0], device_present [2]
	input  logic [2:0]            s_axis_tuser,

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// forward_out [10:0], lateral_out [21:11], vertical_out [32:22], yaw_out [43:33],
	// zero fill [47:44]
	output logic [47:0]           m_axis_tdata,
	// active [0], is_calibrated [1], status [4:2]
	output logic [4:0]            m_axis_tuser,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DZ_W-1:0]       cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always taken; an index past the
	// last register is accepted and ignored.
	// ------------------------------------------------------------------
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone <= DEADZONE_RST;
			cfg_q.src[0]   <= FWD_SRC_RST;
			cfg_q.src[1]   <= LAT_SRC_RST;
			cfg_q.src[2]   <= VERT_SRC_RST;
			cfg_q.src[3]   <= YAW_SRC_RST;
			cfg_q.invert   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_DEADZONE: cfg_q.deadzone <= cfg_data;
				REG_FWD_SRC:  cfg_q.src[0]   <= cfg_data[SRC_W-1:0];
				REG_LAT_SRC:  cfg_q.src[1]   <= cfg_data[SRC_W-1:0];
				REG_VERT_SRC: cfg_q.src[2]   <= cfg_data[SRC_W-1:0];
				REG_YAW_SRC:  cfg_q.src[3]   <= cfg_data[SRC_W-1:0];
				REG_INVERT:   cfg_q.invert   <= cfg_data[NUM_CTRL-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input register. A request moves on into the result register whenever
	// that register is empty or being drained. While a finished result waits
	// downstream the input side still takes one more request, and then holds
	// tready low until the result drains.
	// ------------------------------------------------------------------
	logic  valid_s1;
	cmd_t  cmd_s1;
	logic  present_s1;
	cnt_t  raw_s1 [RAW_AXES];
	logic  s_accept;
	logic  advance;

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1     <= cmd_t'(s_axis_tuser[1:0]);
			present_s1 <= s_axis_tuser[2];
			for (int i = 0; i < RAW_AXES; i++) begin
				raw_s1[i] <= s_axis_tdata[CNT_W*i +: CNT_W];
			end
		end
	end

	// ------------------------------------------------------------------
	// Controller state.
	// ------------------------------------------------------------------
	logic cal_q;
	logic en_q;
	cnt_t held_q [NUM_CTRL];
	cnt_t center_q [NUM_AXES];

	// ------------------------------------------------------------------
	// Axis conditioning. Slots at or past the axis count, and slots past
	// the raw fields of a request, read as zero.
	// ------------------------------------------------------------------
	val_t axes [SLOTS];

	for (genvar i = 0; i < SLOTS; i++) begin : g_axis
		if (i < NUM_AXES && i < RAW_AXES) begin : g_live
			jac_axis u_axis (
				.raw        (raw_s1[i]),
				.center     (center_q[i]),
				.calibrated (cal_q),
				.deadzone   (cfg_q.deadzone),
				.value      (axes[i])
			);
		end else begin : g_zero
			assign axes[i] = '0;
		end
	end

	// Each control picks one conditioned axis and may negate it.
	cnt_t mapped [NUM_CTRL];

	for (genvar k = 0; k < NUM_CTRL; k++) begin : g_map
		jac_map #(
			.NUM_AXES (NUM_AXES)
		) u_map (
			.axes   (axes),
			.src    (cfg_q.src[k]),
			.invert (cfg_q.invert[k]),
			.ctrl   (mapped[k])
		);
	end

	// ------------------------------------------------------------------
	// Command decode. Loss of the device overrides every command and drops
	// calibration, enable and the held controls.
	// ------------------------------------------------------------------
	logic    cal_d;
	logic    en_d;
	logic    hold_zero;
	logic    hold_load;
	logic    center_we;
	status_t status_d;

	always_comb begin
		cal_d     = cal_q;
		en_d      = en_q;
		hold_zero = 1'b0;
		hold_load = 1'b0;
		center_we = 1'b0;
		status_d  = ST_SAMPLED;

		if (!present_s1) begin
			cal_d     = 1'b0;
			en_d      = 1'b0;
			hold_zero = 1'b1;
			if (cmd_s1 == CMD_CALIBRATE || cmd_s1 == CMD_ENABLE) begin
				status_d = ST_NO_DEVICE;
			end else begin
				status_d = ST_DEVICE_LOST;
			end
		end else begin
			case (cmd_s1)
				CMD_SAMPLE: begin
					hold_load = 1'b1;
					status_d  = ST_SAMPLED;
				end
				CMD_CALIBRATE: begin
					center_we = 1'b1;
					hold_zero = 1'b1;
					cal_d     = 1'b1;
					status_d  = ST_CENTERED;
				end
				CMD_ENABLE: begin
					// Enable is refused until centers have been captured, but a
					// block that is already enabled simply confirms it.
					if (en_q) begin
						status_d = ST_ENABLED;
					end else if (!cal_q) begin
						status_d = ST_NOT_CAL;
					end else begin
						en_d     = 1'b1;
						status_d = ST_ENABLED;
					end
				end
				CMD_DISABLE: begin
					en_d      = 1'b0;
					hold_zero = 1'b1;
					status_d  = ST_STANDBY;
				end
				default: begin
				end
			endcase
		end
	end

	// Next values of the held controls, which are also the result controls.
	cnt_t held_d [NUM_CTRL];

	always_comb begin
		for (int k = 0; k < NUM_CTRL; k++) begin
			if (hold_zero) begin
				held_d[k] = '0;
			end else if (hold_load) begin
				held_d[k] = mapped[k];
			end else begin
				held_d[k] = held_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= 1'b0;
			en_q  <= 1'b0;
			for (int k = 0; k < NUM_CTRL; k++) begin
				held_q[k] <= '0;
			end
		end else if (advance) begin
			cal_q <= cal_d;
			en_q  <= en_d;
			for (int k = 0; k < NUM_CTRL; k++) begin
				held_q[k] <= held_d[k];
			end
		end
	end

	// Centers capture the raw axes on a calibrate; axes past the raw fields
	// capture zero.
	for (genvar i = 0; i < NUM_AXES; i++) begin : g_center
		if (i < RAW_AXES) begin : g_raw
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					center_q[i] <= '0;
				end else if (advance && center_we) begin
					center_q[i] <= raw_s1[i];
				end
			end
		end else begin : g_none
			assign center_q[i] = '0;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	logic        m_valid_q;
	logic [47:0] m_data_q;
	logic [4:0]  m_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {4'b0000, held_d[3], held_d[2], held_d[1], held_d[0]};
			m_user_q <= {status_d, cal_d, en_d};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// ===== sv/jac_axis.sv =====
module jac_axis
	import jac_pkg::*;
(
	input  cnt_t             raw,
	input  cnt_t             center,
	input  logic             calibrated,
	input  logic [DZ_W-1:0]  deadzone,
	output val_t             value
);

	val_t diff;
	val_t mag;
	logic in_dead;

	always_comb begin
		if (calibrated) begin
			diff = val_t'(raw) - val_t'(center);
		end else begin
			diff = val_t'(raw);
		end
		mag     = diff[VAL_W-1] ? -diff : diff;
		in_dead = calibrated && ($unsigned(mag) < VAL_W'(deadzone));

		if (in_dead) begin
			value = '0;
		end else if (diff > FULL_POS) begin
			value = FULL_POS;
		end else if (diff < FULL_NEG) begin
			value = FULL_NEG;
		end else begin
			value = diff;
		end
	end

endmodule

// ===== sv/jac_map.sv =====
module jac_map
	import jac_pkg::*;
#(
	parameter int NUM_AXES = 6
) (
	input  val_t              axes [SLOTS],
	input  logic [SRC_W-1:0]  src,
	input  logic              invert,
	output cnt_t              ctrl
);

	val_t picked;
	val_t signed_val;

	always_comb begin
		// A source beyond the configured axis count reads as zero.
		if ({1'b0, src} < (SRC_W + 1)'(NUM_AXES)) begin
			picked = axes[src];
		end else begin
			picked = '0;
		end
		signed_val = invert ? -picked : picked;
		ctrl       = signed_val[CNT_W-1:0];
	end

endmodule
